[hw/rtl/fsfe_pkg.sv]
// Shared types, constants and fixed-point helpers for the shape function unit.
// No dependencies; every other file imports this package.
package fsfe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_NODES = 10;
  localparam int IW        = 32;  // internal datapath width, Q15.16
  localparam int OW        = 22;  // result width, Q5.16
  localparam int XW        = 18;  // coordinate width, Q1.16
  localparam int NW        = 4;   // node index width

  typedef logic signed [IW-1:0]   fx_t;
  typedef logic signed [2*IW-1:0] fxw_t;
  typedef logic signed [OW-1:0]   ov_t;
  typedef logic signed [XW-1:0]   xi_t;
  typedef logic [NW-1:0]          nidx_t;

  typedef enum logic [2:0] {
    EL_L2, EL_L3, EL_L4, EL_T3, EL_T6, EL_T10, EL_TET4, EL_TET10
  } elem_t;

  localparam fx_t ONE     = fx_t'(1) <<< FRAC_BITS;
  localparam fx_t HALF    = fx_t'(1) <<< (FRAC_BITS - 1);
  localparam fx_t OUT_MAX = fx_t'(2097151);
  localparam fx_t OUT_MIN = -fx_t'(2097152);

  // One evaluated point: node count and per-node results
  typedef struct packed {
    nidx_t                 count;
    ov_t [MAX_NODES-1:0]   nv;
    ov_t [MAX_NODES-1:0]   g1;
    ov_t [MAX_NODES-1:0]   g2;
    ov_t [MAX_NODES-1:0]   g3;
  } node_set_t;

  // Divide by 2^sh, round to nearest, ties away from zero
  function automatic fx_t fround(fx_t v, int sh);
    fx_t h;
    fx_t q;
    h = fx_t'(1) <<< (sh - 1);
    q = v + h - fx_t'(v[IW-1]);
    return q >>> sh;
  endfunction

  function automatic fx_t fhalf(fx_t v);
    return fround(v, 1);
  endfunction

  // Fixed-point product, rounded back to FRAC_BITS, ties away from zero
  function automatic fx_t fmul(fx_t a, fx_t b);
    fxw_t p;
    p = a * b;
    p = p + (fxw_t'(1) <<< (FRAC_BITS - 1)) - fxw_t'(p[2*IW-1]);
    p = p >>> FRAC_BITS;
    return p[IW-1:0];
  endfunction

  function automatic ov_t fsat(fx_t v);
    fx_t c;
    c = v;
    if (v > OUT_MAX) c = OUT_MAX;
    if (v < OUT_MIN) c = OUT_MIN;
    return c[OW-1:0];
  endfunction

endpackage

[hw/rtl/fsfe_if.sv]
// Valid/ready channel interfaces: point requests in, node results out.
// Depends on fsfe_pkg for payload types.
interface fsfe_pt_if import fsfe_pkg::*; ();
  logic valid;
  logic ready;
  xi_t  xi_first;
  xi_t  xi_second;
  xi_t  xi_third;
  modport source(output valid, xi_first, xi_second, xi_third, input ready);
  modport sink(input valid, xi_first, xi_second, xi_third, output ready);
endinterface

interface fsfe_res_if import fsfe_pkg::*; ();
  logic  valid;
  logic  ready;
  nidx_t node_index;
  ov_t   shape_value;
  ov_t   deriv_first;
  ov_t   deriv_second;
  ov_t   deriv_third;
  logic  last_node;
  modport source(output valid, node_index, shape_value, deriv_first, deriv_second,
                 deriv_third, last_node, input ready);
  modport sink(input valid, node_index, shape_value, deriv_first, deriv_second,
               deriv_third, last_node, output ready);
endinterface

[hw/rtl/fsfe_poly_pipe.sv]
// Five-stage polynomial evaluator: one point per cycle in unless the output stalls,
// one full node set out. Depends on fsfe_pkg and fsfe_pt_if.
module fsfe_poly_pipe import fsfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  elem_t      elem,
  fsfe_pt_if.sink    pt,
  output logic       out_valid,
  input  logic       out_ready,
  output node_set_t  out_set
);

  // Intermediates carried through stages one to four
  typedef struct packed {
    elem_t e;
    fx_t s, t, u;
    fx_t l2n0, l2n1, hx, xx, ap, ab, bp;
    fx_t q0, q1, q2, q3, q4, q5, q6, q7, q8, q9;
    fx_t m0, m1, m2, c92s, c92t, rr, ss, tt, st27, g19, g29, mrs, msr, mtr, mrt;
    fx_t l3n0, l3n2, apq, abp, abq, bpq, lg0, lg1, lg2, lg3;
    fx_t mm0, mm1, mm2, sr, stt, tr, n9, tcr, tcs, tct;
    fx_t g13, g14, g27, g28, g15, g16, g18n, g23n, g24n, g26;
    fx_t l4n0, l4n1, l4n2, l4n3;
    fx_t tn0, tn1, tn2, tn3, tn4, tn5, tn6, tn7, tn8;
  } pd_t;

  pd_t st1, st2, st3, st4;
  pd_t st1_next, st2_next, st3_next, st4_next;
  node_set_t set5, set5_next;
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  // Advance a stage when it is empty or its successor advances
  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign pt.ready = en1;
  assign out_valid = v5;
  assign out_set   = set5;

  // Stage 1: capture the point and element type
  always_comb begin
    st1_next   = '0;
    st1_next.e = elem;
    st1_next.s = fx_t'(pt.xi_first);
    st1_next.t = fx_t'(pt.xi_second);
    st1_next.u = fx_t'(pt.xi_third);
  end

  // Stage 2: barycentric terms and first products
  always_comb begin
    fx_t x, r, w, zc;
    x  = st1.s;
    r  = ONE - st1.s - st1.t;
    w  = r - st1.u;
    zc = (st1.e == EL_TET10) ? w : r;
    st2_next      = st1;
    st2_next.l2n0 = fhalf(ONE - x);
    st2_next.l2n1 = fhalf(ONE + x);
    st2_next.hx   = fhalf(x);
    st2_next.xx   = fmul(x, x);
    st2_next.ap   = fmul(x - ONE, x * 3 - ONE);
    st2_next.ab   = fmul(x - ONE, x + ONE);
    st2_next.bp   = fmul(x + ONE, x * 3 - ONE);
    st2_next.q0   = fmul(zc, zc * 2 - ONE);
    st2_next.q1   = fmul(st1.s, st1.s * 2 - ONE);
    st2_next.q2   = fmul(st1.t, st1.t * 2 - ONE);
    st2_next.q3   = fmul(st1.u, st1.u * 2 - ONE);
    st2_next.q4   = fmul(st1.s * 4, zc);
    st2_next.q5   = fmul(st1.s * 4, st1.t);
    st2_next.q6   = fmul(st1.t * 4, zc);
    st2_next.q7   = fmul(st1.u * 4, zc);
    st2_next.q8   = fmul(st1.t * 4, st1.u);
    st2_next.q9   = fmul(st1.s * 4, st1.u);
    st2_next.m0   = fmul(r, r * 3 - ONE * 2);
    st2_next.m1   = fmul(st1.s, st1.s * 3 - ONE * 2);
    st2_next.m2   = fmul(st1.t, st1.t * 3 - ONE * 2);
    st2_next.c92s = fround(st1.s * 9, 1);
    st2_next.c92t = fround(st1.t * 9, 1);
    st2_next.rr   = fmul(r, r);
    st2_next.ss   = fmul(st1.s, st1.s);
    st2_next.tt   = fmul(st1.t, st1.t);
    st2_next.st27 = fmul(st1.s * 27, st1.t);
    st2_next.g19  = fmul(st1.t * 27, r - st1.s);
    st2_next.g29  = fmul(st1.s * 27, r - st1.t);
    st2_next.mrs  = fmul(r, r - st1.s * 2);
    st2_next.msr  = fmul(st1.s, r * 2 - st1.s);
    st2_next.mtr  = fmul(st1.t, r * 2 - st1.t);
    st2_next.mrt  = fmul(r, r - st1.t * 2);
  end

  // Stage 3: second products
  always_comb begin
    fx_t x, r, r3, s3, t3, r6, s6, t6;
    x  = st2.s;
    r  = ONE - st2.s - st2.t;
    r3 = r * 3 - ONE;
    s3 = st2.s * 3 - ONE;
    t3 = st2.t * 3 - ONE;
    r6 = r * 6 - ONE;
    s6 = st2.s * 6 - ONE;
    t6 = st2.t * 6 - ONE;
    st3_next      = st2;
    st3_next.l3n0 = fmul(st2.hx, x - ONE);
    st3_next.l3n2 = fmul(st2.hx, x + ONE);
    st3_next.apq  = fmul(st2.ap, x * 3 + ONE);
    st3_next.abp  = fmul(st2.ab, x * 3 - ONE);
    st3_next.abq  = fmul(st2.ab, x * 3 + ONE);
    st3_next.bpq  = fmul(st2.bp, x * 3 + ONE);
    st3_next.lg0  = fround(-(st2.xx * 27) + x * 18 + ONE, 4);
    st3_next.lg1  = fround((st2.xx * 9 - x * 2 - ONE * 3) * 9, 4);
    st3_next.lg2  = -fround((st2.xx * 9 + x * 2 - ONE * 3) * 9, 4);
    st3_next.lg3  = fround(st2.xx * 27 + x * 18 - ONE, 4);
    st3_next.mm0  = fmul(st2.m0, r3);
    st3_next.mm1  = fmul(st2.m1, s3);
    st3_next.mm2  = fmul(st2.m2, t3);
    st3_next.sr   = fmul(st2.c92s, r);
    st3_next.stt  = fmul(st2.c92s, st2.t);
    st3_next.tr   = fmul(st2.c92t, r);
    st3_next.n9   = fmul(st2.st27, r);
    st3_next.tcr  = fhalf(-(st2.rr * 27) + r * 18 - ONE * 2);
    st3_next.tcs  = fhalf(-(st2.ss * 27) + st2.s * 18 - ONE * 2);
    st3_next.tct  = fhalf(-(st2.tt * 27) + st2.t * 18 - ONE * 2);
    st3_next.g13  = fhalf(st2.mrs * 27 + (st2.s - r) * 9);
    st3_next.g14  = fhalf(st2.msr * 27 + (st2.s - r) * 9);
    st3_next.g27  = fhalf(st2.mtr * 27 + (st2.t - r) * 9);
    st3_next.g28  = fhalf(st2.mrt * 27 + (st2.t - r) * 9);
    st3_next.g15  = fmul(st2.c92t, s6);
    st3_next.g16  = fmul(st2.c92t, t3);
    st3_next.g18n = fmul(st2.c92t, r6);
    st3_next.g23n = fmul(st2.c92s, r6);
    st3_next.g24n = fmul(st2.c92s, s3);
    st3_next.g26  = fmul(st2.c92s, t6);
  end

  // Stage 4: third products and final scaling
  always_comb begin
    fx_t r, r3, s3, t3;
    r  = ONE - st3.s - st3.t;
    r3 = r * 3 - ONE;
    s3 = st3.s * 3 - ONE;
    t3 = st3.t * 3 - ONE;
    st4_next      = st3;
    st4_next.l4n0 = -fround(st3.apq, 4);
    st4_next.l4n1 = fround(st3.abp * 9, 4);
    st4_next.l4n2 = -fround(st3.abq * 9, 4);
    st4_next.l4n3 = fround(st3.bpq, 4);
    st4_next.tn0  = fhalf(st3.mm0);
    st4_next.tn1  = fhalf(st3.mm1);
    st4_next.tn2  = fhalf(st3.mm2);
    st4_next.tn3  = fmul(st3.sr, r3);
    st4_next.tn4  = fmul(st3.sr, s3);
    st4_next.tn5  = fmul(st3.stt, s3);
    st4_next.tn6  = fmul(st3.stt, t3);
    st4_next.tn7  = fmul(st3.tr, t3);
    st4_next.tn8  = fmul(st3.tr, r3);
  end

  // Stage 5: select by element type and saturate
  always_comb begin
    fx_t nv [MAX_NODES];
    fx_t g1 [MAX_NODES];
    fx_t g2 [MAX_NODES];
    fx_t g3 [MAX_NODES];
    fx_t x, s, t, u, r, w;
    x = st4.s;
    s = st4.s;
    t = st4.t;
    u = st4.u;
    r = ONE - s - t;
    w = r - u;
    for (int i = 0; i < MAX_NODES; i++) begin
      nv[i] = '0;
      g1[i] = '0;
      g2[i] = '0;
      g3[i] = '0;
    end
    set5_next = '0;
    case (st4.e)
      EL_L2: begin
        set5_next.count = nidx_t'(2);
        nv[0] = st4.l2n0;  nv[1] = st4.l2n1;
        g1[0] = -HALF;     g1[1] = HALF;
      end
      EL_L3: begin
        set5_next.count = nidx_t'(3);
        nv[0] = st4.l3n0;  nv[1] = ONE - st4.xx;  nv[2] = st4.l3n2;
        g1[0] = x - HALF;  g1[1] = -x;            g1[2] = x + HALF;
      end
      EL_L4: begin
        set5_next.count = nidx_t'(4);
        nv[0] = st4.l4n0;  nv[1] = st4.l4n1;  nv[2] = st4.l4n2;  nv[3] = st4.l4n3;
        g1[0] = st4.lg0;   g1[1] = st4.lg1;   g1[2] = st4.lg2;   g1[3] = st4.lg3;
      end
      EL_T3: begin
        set5_next.count = nidx_t'(3);
        nv[0] = r;  nv[1] = s;  nv[2] = t;
        g1[0] = -ONE;  g1[1] = ONE;
        g2[0] = -ONE;  g2[2] = ONE;
      end
      EL_T6: begin
        set5_next.count = nidx_t'(6);
        nv[0] = st4.q0;  nv[1] = st4.q1;  nv[2] = st4.q2;
        nv[3] = st4.q4;  nv[4] = st4.q5;  nv[5] = st4.q6;
        g1[0] = ONE - r * 4;  g1[1] = s * 4 - ONE;  g1[3] = (r - s) * 4;
        g1[4] = t * 4;        g1[5] = -(t * 4);
        g2[0] = ONE - r * 4;  g2[2] = t * 4 - ONE;  g2[3] = -(s * 4);
        g2[4] = s * 4;        g2[5] = (r - t) * 4;
      end
      EL_T10: begin
        set5_next.count = nidx_t'(10);
        nv[0] = st4.tn0;  nv[1] = st4.tn1;  nv[2] = st4.tn2;  nv[3] = st4.tn3;
        nv[4] = st4.tn4;  nv[5] = st4.tn5;  nv[6] = st4.tn6;  nv[7] = st4.tn7;
        nv[8] = st4.tn8;  nv[9] = st4.n9;
        g1[0] = st4.tcr;   g1[1] = -st4.tcs;  g1[3] = st4.g13;   g1[4] = st4.g14;
        g1[5] = st4.g15;   g1[6] = st4.g16;   g1[7] = -st4.g16;  g1[8] = -st4.g18n;
        g1[9] = st4.g19;
        g2[0] = st4.tcr;   g2[2] = -st4.tct;  g2[3] = -st4.g23n; g2[4] = -st4.g24n;
        g2[5] = st4.g24n;  g2[6] = st4.g26;   g2[7] = st4.g27;   g2[8] = st4.g28;
        g2[9] = st4.g29;
      end
      EL_TET4: begin
        set5_next.count = nidx_t'(4);
        nv[0] = w;  nv[1] = s;  nv[2] = t;  nv[3] = u;
        g1[0] = -ONE;  g1[1] = ONE;
        g2[0] = -ONE;  g2[2] = ONE;
        g3[0] = -ONE;  g3[3] = ONE;
      end
      EL_TET10: begin
        set5_next.count = nidx_t'(10);
        nv[0] = st4.q0;  nv[1] = st4.q1;  nv[2] = st4.q2;  nv[3] = st4.q3;
        nv[4] = st4.q4;  nv[5] = st4.q5;  nv[6] = st4.q6;  nv[7] = st4.q7;
        nv[8] = st4.q8;  nv[9] = st4.q9;
        g1[0] = ONE - w * 4;  g2[0] = ONE - w * 4;  g3[0] = ONE - w * 4;
        g1[1] = s * 4 - ONE;  g2[2] = t * 4 - ONE;  g3[3] = u * 4 - ONE;
        g1[4] = (w - s) * 4;  g2[4] = -(s * 4);     g3[4] = -(s * 4);
        g1[5] = t * 4;        g2[5] = s * 4;
        g1[6] = -(t * 4);     g2[6] = (w - t) * 4;  g3[6] = -(t * 4);
        g1[7] = -(u * 4);     g2[7] = -(u * 4);     g3[7] = (w - u) * 4;
        g2[8] = u * 4;        g3[8] = t * 4;
        g1[9] = u * 4;        g3[9] = s * 4;
      end
      default: begin
        set5_next.count = nidx_t'(2);
      end
    endcase
    for (int i = 0; i < MAX_NODES; i++) begin
      set5_next.nv[i] = fsat(nv[i]);
      set5_next.g1[i] = fsat(g1[i]);
      set5_next.g2[i] = fsat(g2[i]);
      set5_next.g3[i] = fsat(g3[i]);
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= pt.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Payload registers, held while a stage stalls
  always_ff @(posedge clk) begin
    if (en1) st1 <= st1_next;
    if (en2) st2 <= st2_next;
    if (en3) st3 <= st3_next;
    if (en4) st4 <= st4_next;
    if (en5) set5 <= set5_next;
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v5 && !out_ready) |=> (v5 && $stable(set5)))
    else $error("node set changed while stalled");

endmodule

[hw/rtl/fsfe_node_ser.sv]
// Node serializer: holds one evaluated point and emits one node result per cycle
// while res.ready is high. Depends on fsfe_pkg and fsfe_res_if.
module fsfe_node_ser import fsfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  node_set_t  in_set,
  fsfe_res_if.source res
);

  node_set_t held;
  logic      busy;
  nidx_t     node_k;
  logic      last;
  logic      take;
  logic      load;

  assign last     = (node_k == held.count - nidx_t'(1));
  assign take     = busy && res.ready;
  assign in_ready = !busy || (take && last);
  assign load     = in_valid && in_ready;

  // Drive the current node from the held set
  assign res.valid        = busy;
  assign res.node_index   = node_k;
  assign res.shape_value  = held.nv[node_k];
  assign res.deriv_first  = held.g1[node_k];
  assign res.deriv_second = held.g2[node_k];
  assign res.deriv_third  = held.g3[node_k];
  assign res.last_node    = last;

  // Advance node index, drop the set after its last node
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      node_k <= '0;
    end else if (load) begin
      busy   <= 1'b1;
      node_k <= '0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        node_k <= node_k + nidx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= in_set;
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (node_k < held.count))
    else $error("node index beyond node count");

  a_load_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    load |=> (busy && node_k == '0))
    else $error("new point does not start at node zero");

  a_no_early_drop: assert property (@(posedge clk) disable iff (rst)
    (take && !last) |=> (busy && node_k == $past(node_k) + nidx_t'(1)))
    else $error("point dropped before its last node");

endmodule

[hw/rtl/fem_shape_function_eval_unit.sv]
// Top level of the Lagrange shape function unit: element type register,
// evaluator pipeline and node serializer. Depends on fsfe_pkg, fsfe_if,
// fsfe_poly_pipe and fsfe_node_ser.
//
//   channel  dir  handshake        payload
//   pt       in   valid/ready      xi_first, xi_second, xi_third (Q1.16)
//   res      out  valid/ready      node_index, shape_value, deriv_*, last_node
//   cfg      in   cfg_wr_en        cfg_wr_data = element type
//
// A point passes through the evaluator pipeline, then the serializer emits its
// 2 to 10 node results one by one; the single output port sets the rate.
// The pipeline keeps taking requests while a result waits; it fills up to
// five points deep before pt.ready drops.
// Reset (rst, synchronous) empties all stages and sets the element type to L2.
module fem_shape_function_eval_unit import fsfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  fsfe_pt_if.sink     pt,
  fsfe_res_if.source  res
);

  elem_t     element_type;
  logic      set_valid;
  logic      set_ready;
  node_set_t set_data;

  // Hold the element type register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_type <= EL_L2;
    end else if (cfg_wr_en) begin
      element_type <= elem_t'(cfg_wr_data);
    end
  end

  fsfe_poly_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .elem      (element_type),
    .pt        (pt),
    .out_valid (set_valid),
    .out_ready (set_ready),
    .out_set   (set_data)
  );

  fsfe_node_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (set_valid),
    .in_ready (set_ready),
    .in_set   (set_data),
    .res      (res)
  );

endmodule

[sim/tb_fem_shape_function_eval_unit.sv]
// Testbench for fem_shape_function_eval_unit: random and corner points for every
// element type, checked node by node against a 64-bit fixed-point predictor.
// Depends on fsfe_pkg, fsfe_if and the unit's RTL.
module tb_fem_shape_function_eval_unit;
  import fsfe_pkg::*;

  localparam longint Q_ONE  = 64'sd1 <<< 16;
  localparam longint Q_HALF = 64'sd1 <<< 15;
  localparam longint Q_LIM  = 64'sh3FFFFFFFFFFFFFFF;
  localparam int     STALL_LIMIT = 4000;

  typedef struct {
    xi_t xa;
    xi_t xb;
    xi_t xc;
  } point_t;

  typedef struct {
    nidx_t node;
    ov_t   shape;
    ov_t   d1;
    ov_t   d2;
    ov_t   d3;
    logic  last;
  } node_res_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [2:0] cfg_wr_data;

  fsfe_pt_if  pt_ch();
  fsfe_res_if res_ch();

  fem_shape_function_eval_unit i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .pt(pt_ch), .res(res_ch)
  );

  point_t    pending_points[$];
  node_res_t expected_nodes[$];
  elem_t     elem_cfg;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        fail_count;
  int        quiet_cycles;
  logic      pt_taken;
  longint    nv[10], g1[10], g2[10], g3[10];

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating fixed-point arithmetic
  function automatic longint q_sat(longint v);
    if (v > Q_LIM) return Q_LIM;
    if (v < -Q_LIM) return -Q_LIM;
    return v;
  endfunction

  function automatic longint q_add(longint a, longint b);
    return q_sat(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return q_sat(a - b);
  endfunction

  // Product rounded to nearest, ties away from zero
  function automatic longint q_mul(longint a, longint b);
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] p;
    logic         neg;
    longint       r;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    p = ((ua * ub) + 128'(Q_HALF)) >> 16;
    if (p > 128'(Q_LIM)) p = 128'(Q_LIM);
    r = longint'(p[63:0]);
    return neg ? -r : r;
  endfunction

  function automatic longint k(longint n);
    return n * Q_ONE;
  endfunction

  function automatic ov_t to_out(longint v);
    if (v > 2097151) v = 2097151;
    if (v < -2097152) v = -2097152;
    return v[21:0];
  endfunction

  // Mixed-edge term of the cubic triangle
  function automatic longint tri10_mixed(longint u, longint v);
    return q_mul(Q_HALF, q_add(q_mul(k(27), q_mul(u, q_sub(q_mul(k(2), v), u))),
                               q_mul(k(9), q_sub(u, v))));
  endfunction

  // Corner-node derivative of the cubic triangle
  function automatic longint tri10_corner(longint u);
    return q_mul(Q_HALF, q_sub(q_add(-q_mul(k(27), q_mul(u, u)), q_mul(k(18), u)), k(2)));
  endfunction

  // Evaluate all nodes of the current element and queue the node results
  task automatic predict_point(point_t p);
    longint s, t, u, r, w, x3, pp, qq, xx, q9, q27, l2, l18, a, b, c0;
    longint s3, t3, r3, s6, t6, r6;
    int n;
    s = longint'(p.xa);
    t = longint'(p.xb);
    u = longint'(p.xc);
    for (int i = 0; i < 10; i++) begin
      nv[i] = 0; g1[i] = 0; g2[i] = 0; g3[i] = 0;
    end
    case (elem_cfg)
      EL_L2: begin
        nv[0] = q_mul(Q_HALF, q_sub(Q_ONE, s));
        nv[1] = q_mul(Q_HALF, q_add(Q_ONE, s));
        g1[0] = -Q_HALF; g1[1] = Q_HALF;
        n = 2;
      end
      EL_L3: begin
        a = q_mul(Q_HALF, s);
        nv[0] = q_mul(a, q_sub(s, Q_ONE));
        nv[1] = q_sub(Q_ONE, q_mul(s, s));
        nv[2] = q_mul(a, q_add(s, Q_ONE));
        g1[0] = q_sub(s, Q_HALF); g1[1] = -s; g1[2] = q_add(s, Q_HALF);
        n = 3;
      end
      EL_L4: begin
        a = q_sub(s, Q_ONE); b = q_add(s, Q_ONE);
        x3 = q_mul(k(3), s);
        pp = q_sub(x3, Q_ONE); qq = q_add(x3, Q_ONE);
        xx = q_mul(s, s);
        q9 = q_mul(k(9), xx); q27 = q_mul(k(27), xx);
        l2 = q_mul(k(2), s); l18 = q_mul(k(18), s);
        nv[0] = q_mul(-Q_ONE / 16, q_mul(q_mul(a, pp), qq));
        nv[1] = q_mul(k(9) / 16, q_mul(q_mul(a, b), pp));
        nv[2] = q_mul(-k(9) / 16, q_mul(q_mul(a, b), qq));
        nv[3] = q_mul(Q_ONE / 16, q_mul(q_mul(b, pp), qq));
        g1[0] = q_mul(Q_ONE / 16, q_add(q_add(-q27, l18), Q_ONE));
        g1[1] = q_mul(k(9) / 16, q_sub(q_sub(q9, l2), k(3)));
        g1[2] = q_mul(-k(9) / 16, q_sub(q_add(q9, l2), k(3)));
        g1[3] = q_mul(Q_ONE / 16, q_sub(q_add(q27, l18), Q_ONE));
        n = 4;
      end
      EL_T3: begin
        nv[0] = q_sub(q_sub(Q_ONE, s), t); nv[1] = s; nv[2] = t;
        g1[0] = -Q_ONE; g1[1] = Q_ONE; g2[0] = -Q_ONE; g2[2] = Q_ONE;
        n = 3;
      end
      EL_T6: begin
        r = q_sub(q_sub(Q_ONE, s), t);
        nv[0] = q_mul(r, q_sub(q_mul(k(2), r), Q_ONE));
        nv[1] = q_mul(s, q_sub(q_mul(k(2), s), Q_ONE));
        nv[2] = q_mul(t, q_sub(q_mul(k(2), t), Q_ONE));
        nv[3] = q_mul(q_mul(k(4), s), r);
        nv[4] = q_mul(q_mul(k(4), s), t);
        nv[5] = q_mul(q_mul(k(4), t), r);
        g1[0] = q_sub(Q_ONE, q_mul(k(4), r));
        g1[1] = q_sub(q_mul(k(4), s), Q_ONE);
        g1[3] = q_mul(k(4), q_sub(r, s));
        g1[4] = q_mul(k(4), t);
        g1[5] = -q_mul(k(4), t);
        g2[0] = g1[0];
        g2[2] = q_sub(q_mul(k(4), t), Q_ONE);
        g2[3] = -q_mul(k(4), s);
        g2[4] = q_mul(k(4), s);
        g2[5] = q_mul(k(4), q_sub(r, t));
        n = 6;
      end
      EL_T10: begin
        r = q_sub(q_sub(Q_ONE, s), t);
        s3 = q_sub(q_mul(k(3), s), Q_ONE);
        t3 = q_sub(q_mul(k(3), t), Q_ONE);
        r3 = q_sub(q_mul(k(3), r), Q_ONE);
        s6 = q_sub(q_mul(k(6), s), Q_ONE);
        t6 = q_sub(q_mul(k(6), t), Q_ONE);
        r6 = q_sub(q_mul(k(6), r), Q_ONE);
        a = k(9) / 2;
        nv[0] = q_mul(Q_HALF, q_mul(q_mul(r, q_sub(q_mul(k(3), r), k(2))), r3));
        nv[1] = q_mul(Q_HALF, q_mul(q_mul(s, q_sub(q_mul(k(3), s), k(2))), s3));
        nv[2] = q_mul(Q_HALF, q_mul(q_mul(t, q_sub(q_mul(k(3), t), k(2))), t3));
        nv[3] = q_mul(q_mul(q_mul(a, s), r), r3);
        nv[4] = q_mul(q_mul(q_mul(a, s), r), s3);
        nv[5] = q_mul(q_mul(q_mul(a, s), t), s3);
        nv[6] = q_mul(q_mul(q_mul(a, s), t), t3);
        nv[7] = q_mul(q_mul(q_mul(a, t), r), t3);
        nv[8] = q_mul(q_mul(q_mul(a, t), r), r3);
        nv[9] = q_mul(q_mul(q_mul(k(27), s), t), r);
        g1[0] = tri10_corner(r);
        g1[1] = -tri10_corner(s);
        g1[3] = q_mul(Q_HALF, q_add(q_mul(k(27), q_mul(r, q_sub(r, q_mul(k(2), s)))),
                                    q_mul(k(9), q_sub(s, r))));
        g1[4] = tri10_mixed(s, r);
        g1[5] = q_mul(q_mul(a, t), s6);
        g1[6] = q_mul(q_mul(a, t), t3);
        g1[7] = -q_mul(q_mul(a, t), t3);
        g1[8] = -q_mul(q_mul(a, t), r6);
        g1[9] = q_mul(q_mul(k(27), t), q_sub(r, s));
        g2[0] = g1[0];
        g2[2] = -tri10_corner(t);
        g2[3] = -q_mul(q_mul(a, s), r6);
        g2[4] = -q_mul(q_mul(a, s), s3);
        g2[5] = q_mul(q_mul(a, s), s3);
        g2[6] = q_mul(q_mul(a, s), t6);
        g2[7] = tri10_mixed(t, r);
        g2[8] = q_mul(Q_HALF, q_add(q_mul(k(27), q_mul(r, q_sub(r, q_mul(k(2), t)))),
                                    q_mul(k(9), q_sub(t, r))));
        g2[9] = q_mul(q_mul(k(27), s), q_sub(r, t));
        n = 10;
      end
      EL_TET4: begin
        nv[0] = q_sub(q_sub(q_sub(Q_ONE, s), t), u);
        nv[1] = s; nv[2] = t; nv[3] = u;
        g1[0] = -Q_ONE; g1[1] = Q_ONE;
        g2[0] = -Q_ONE; g2[2] = Q_ONE;
        g3[0] = -Q_ONE; g3[3] = Q_ONE;
        n = 4;
      end
      default: begin
        w = q_sub(q_sub(q_sub(Q_ONE, s), t), u);
        c0 = q_sub(Q_ONE, q_mul(k(4), w));
        nv[0] = q_mul(w, q_sub(q_mul(k(2), w), Q_ONE));
        nv[1] = q_mul(s, q_sub(q_mul(k(2), s), Q_ONE));
        nv[2] = q_mul(t, q_sub(q_mul(k(2), t), Q_ONE));
        nv[3] = q_mul(u, q_sub(q_mul(k(2), u), Q_ONE));
        nv[4] = q_mul(q_mul(k(4), s), w);
        nv[5] = q_mul(q_mul(k(4), s), t);
        nv[6] = q_mul(q_mul(k(4), t), w);
        nv[7] = q_mul(q_mul(k(4), u), w);
        nv[8] = q_mul(q_mul(k(4), t), u);
        nv[9] = q_mul(q_mul(k(4), s), u);
        g1[0] = c0; g2[0] = c0; g3[0] = c0;
        g1[1] = q_sub(q_mul(k(4), s), Q_ONE);
        g2[2] = q_sub(q_mul(k(4), t), Q_ONE);
        g3[3] = q_sub(q_mul(k(4), u), Q_ONE);
        g1[4] = q_mul(k(4), q_sub(w, s)); g2[4] = -q_mul(k(4), s); g3[4] = -q_mul(k(4), s);
        g1[5] = q_mul(k(4), t);           g2[5] = q_mul(k(4), s);
        g1[6] = -q_mul(k(4), t); g2[6] = q_mul(k(4), q_sub(w, t)); g3[6] = -q_mul(k(4), t);
        g1[7] = -q_mul(k(4), u); g2[7] = -q_mul(k(4), u); g3[7] = q_mul(k(4), q_sub(w, u));
        g2[8] = q_mul(k(4), u);           g3[8] = q_mul(k(4), t);
        g1[9] = q_mul(k(4), u);           g3[9] = q_mul(k(4), s);
        n = 10;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      node_res_t e;
      e.node  = nidx_t'(i);
      e.shape = to_out(nv[i]);
      e.d1    = to_out(g1[i]);
      e.d2    = to_out(g2[i]);
      e.d3    = to_out(g3[i]);
      e.last  = (i == n - 1);
      expected_nodes.push_back(e);
    end
  endtask

  // Request driver: hold a point until taken, then advance or idle
  always @(negedge clk) begin
    if (rst) begin
      pt_ch.valid <= 1'b0;
    end else if (!pt_ch.valid || pt_taken) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        pt_ch.xi_first  <= p.xa;
        pt_ch.xi_second <= p.xb;
        pt_ch.xi_third  <= p.xc;
        pt_ch.valid     <= 1'b1;
      end else begin
        pt_ch.valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    pt_taken = !rst && pt_ch.valid && pt_ch.ready;
    if (pt_taken) begin
      point_t p;
      p.xa = pt_ch.xi_first;
      p.xb = pt_ch.xi_second;
      p.xc = pt_ch.xi_third;
      predict_point(p);
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_nodes.size() == 0) begin
        $display("%0t: unexpected result node %0d", $time, res_ch.node_index);
        fail_count++;
      end else begin
        node_res_t e;
        e = expected_nodes.pop_front();
        if (res_ch.node_index !== e.node || res_ch.shape_value !== e.shape ||
            res_ch.deriv_first !== e.d1 || res_ch.deriv_second !== e.d2 ||
            res_ch.deriv_third !== e.d3 || res_ch.last_node !== e.last) begin
          $display("%0t: mismatch expected node %0d N %0d d %0d %0d %0d last %0b", $time,
                   e.node, e.shape, e.d1, e.d2, e.d3, e.last);
          $display("%0t:            actual node %0d N %0d d %0d %0d %0d last %0b", $time,
                   res_ch.node_index, res_ch.shape_value, res_ch.deriv_first,
                   res_ch.deriv_second, res_ch.deriv_third, res_ch.last_node);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (pt_taken || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** fem_shape_function_eval_unit: FAILED **");
      $finish;
    end
  end

  function automatic xi_t rand_coord();
    if ($urandom_range(99) < 70) return xi_t'($signed($urandom_range(131072)) - 65536);
    return xi_t'($urandom);
  endfunction

  // Write the element type, queue a phase of points and drain it
  task automatic run_phase(elem_t el, int mode, bit corners, int n_rand);
    point_t p;
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= el;
    elem_cfg = el;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    send_idle_pct  = (mode == 1) ? 69 : (mode == 3) ? 10 : 0;
    recv_stall_pct = (mode == 2) ? 69 : (mode == 3) ? 10 : 0;
    if (corners) begin
      p.xa = 18'sh1FFFF; p.xb = 18'sh1FFFF; p.xc = 18'sh1FFFF; pending_points.push_back(p);
      p.xa = -18'sh20000; p.xb = -18'sh20000; p.xc = -18'sh20000; pending_points.push_back(p);
      p.xa = 0; p.xb = 0; p.xc = 0; pending_points.push_back(p);
    end
    for (int i = 0; i < n_rand; i++) begin
      p.xa = rand_coord(); p.xb = rand_coord(); p.xc = rand_coord();
      pending_points.push_back(p);
    end
    // Hold further requests until every expected result has come
    while (pending_points.size() != 0 || pt_ch.valid || expected_nodes.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    elem_t order[12];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = EL_L2;
    pt_ch.valid = 1'b0;
    pt_ch.xi_first = '0;
    pt_ch.xi_second = '0;
    pt_ch.xi_third = '0;
    res_ch.ready = 1'b0;
    pt_taken = 1'b0;
    elem_cfg = EL_L2;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    quiet_cycles = 0;
    order = '{EL_L2, EL_L3, EL_L4, EL_T3, EL_T6, EL_T10, EL_TET4, EL_TET10,
              EL_TET10, EL_L2, EL_T10, EL_L4};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 12; ph++) run_phase(order[ph], ph % 4, ph < 8, 20);
    if (fail_count == 0) begin
      $display("** fem_shape_function_eval_unit: PASSED **");
    end else begin
      $display("** fem_shape_function_eval_unit: FAILED **");
    end
    $finish;
  end

endmodule
